// File: rtl/hxm_pkg.sv
// hxm_pkg: types and constants shared by the hex-x motor mixer files
// no dependencies
`default_nettype none

package hxm_pkg;

  localparam int MOTORS    = 6;
  localparam int MIX_W     = 15;
  localparam int SUM_W     = 25;
  localparam int FRAC_BITS = 10;

  localparam logic [11:0] IDLE_CMD  = 12'd1000;
  localparam logic [9:0]  PITCH_WT  = 10'd887;
  localparam logic [9:0]  FRAC_RND  = 10'd1023;

  localparam logic [1:0] CFG_MIN_THROTTLE = 2'd0;
  localparam logic [1:0] CFG_MAX_THROTTLE = 2'd1;
  localparam logic [1:0] CFG_RC_MIN_CHECK = 2'd2;

  localparam logic [11:0] RST_MIN_THROTTLE = 12'd1100;
  localparam logic [11:0] RST_MAX_THROTTLE = 12'd1900;
  localparam logic [11:0] RST_RC_MIN_CHECK = 12'd1150;

  typedef logic signed [MIX_W-1:0] mix_t;

  typedef struct packed {
    logic [11:0]        throttle;
    logic signed [11:0] roll_term;
    logic signed [11:0] pitch_term;
    logic signed [11:0] yaw_term;
    logic               armed;
    logic               alt_hold;
    logic [11:0]        rc_throttle;
  } in_t;

  typedef struct packed {
    logic [11:0] motor_rear_left;
    logic [11:0] motor_front_right;
    logic [11:0] motor_rear_right;
    logic [11:0] motor_front_left;
    logic [11:0] motor_left;
    logic [11:0] motor_right;
    logic        forced_idle;
  } out_t;

  typedef struct packed {
    logic [11:0] min_throttle;
    logic [11:0] max_throttle;
    logic [11:0] rc_min_check;
  } cfg_t;

  typedef struct packed {
    mix_t [MOTORS-1:0] m;
    logic              idle;
  } mix_item_t;

endpackage

`default_nettype wire

// File: rtl/hxm_mix.sv
// hxm_mix: two pipeline stages, pitch product and idle test, then the six mix sums
// depends on hxm_pkg
`default_nettype none

module hxm_mix
  import hxm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_t       in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output mix_item_t      out_item
);

  function automatic mix_t trunc_frac(input logic signed [SUM_W-1:0] s);
    logic signed [SUM_W-1:0] a;
    begin
      a = s[SUM_W-1] ? s + $signed({{(SUM_W-FRAC_BITS){1'b0}}, FRAC_RND}) : s;
      return mix_t'(a >>> FRAC_BITS);
    end
  endfunction

  logic               s1_valid;
  logic [11:0]        t1;
  logic signed [11:0] r1;
  logic signed [11:0] y1;
  logic signed [22:0] pw1;
  logic               idle1;
  logic               en1;
  logic               en2;

  logic signed [22:0]      pw;
  logic                    idle;
  logic signed [SUM_W-1:0] tf;
  logic signed [SUM_W-1:0] rh;
  logic signed [SUM_W-1:0] pf;
  logic signed [SUM_W-1:0] yf;
  logic signed [MIX_W-1:0] ts;
  logic signed [MIX_W-1:0] rs;
  logic signed [MIX_W-1:0] ys;
  mix_item_t               mix;

  assign en2      = !out_valid || out_ready;
  assign en1      = !s1_valid || en2;
  assign in_ready = en1;

  // stage 1
  assign pw   = $signed(in_item.pitch_term) * $signed({1'b0, PITCH_WT});
  assign idle = !in_item.armed ||
                (!in_item.alt_hold && (in_item.rc_throttle < cfg.rc_min_check));

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      t1    <= in_item.throttle;
      r1    <= in_item.roll_term;
      y1    <= in_item.yaw_term;
      pw1   <= pw;
      idle1 <= idle;
    end
  end

  // stage 2
  always_comb begin
    tf = $signed({3'b000, t1, 10'd0});
    rh = $signed({{4{r1[11]}}, r1, 9'd0});
    pf = $signed({{2{pw1[22]}}, pw1});
    yf = $signed({{3{y1[11]}}, y1, 10'd0});
    ts = $signed({3'b000, t1});
    rs = $signed({{3{r1[11]}}, r1});
    ys = $signed({{3{y1[11]}}, y1});
    mix.m[0] = trunc_frac(tf + rh + pf - yf);
    mix.m[1] = trunc_frac(tf - rh - pf + yf);
    mix.m[2] = trunc_frac(tf - rh + pf + yf);
    mix.m[3] = trunc_frac(tf + rh - pf - yf);
    mix.m[4] = ts + rs + ys;
    mix.m[5] = ts - rs - ys;
    mix.idle = idle1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      out_item <= mix;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hxm_limit.sv
// hxm_limit: two pipeline stages, peak and excess search, then shift, clamp and idle override
// depends on hxm_pkg
`default_nettype none

module hxm_limit
  import hxm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cfg_t      cfg,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire mix_item_t in_item,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_t           out_item
);

  logic              s3_valid;
  mix_t [MOTORS-1:0] m3;
  mix_t              exc3;
  logic              idle3;
  logic              en3;
  logic              en4;

  mix_t              a01;
  mix_t              a23;
  mix_t              a45;
  mix_t              a03;
  mix_t              top;
  mix_t              hi15;
  mix_t              exc;

  logic signed [MIX_W:0] lo16;
  logic signed [MIX_W:0] hi16;
  logic signed [MIX_W:0] adj [MOTORS];
  logic [11:0]           cmd [MOTORS];
  out_t                  res;

  assign en4      = !out_valid || out_ready;
  assign en3      = !s3_valid || en4;
  assign in_ready = en3;

  // stage 3: largest command and its excess over the ceiling
  always_comb begin
    a01  = (in_item.m[1] > in_item.m[0]) ? in_item.m[1] : in_item.m[0];
    a23  = (in_item.m[3] > in_item.m[2]) ? in_item.m[3] : in_item.m[2];
    a45  = (in_item.m[5] > in_item.m[4]) ? in_item.m[5] : in_item.m[4];
    a03  = (a23 > a01) ? a23 : a01;
    top  = (a45 > a03) ? a45 : a03;
    hi15 = $signed({3'b000, cfg.max_throttle});
    exc  = (top > hi15) ? mix_t'(top - hi15) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) begin
      m3    <= in_item.m;
      exc3  <= exc;
      idle3 <= in_item.idle;
    end
  end

  // stage 4: shift down, clamp low bound first, then idle override
  always_comb begin
    lo16 = $signed({4'b0000, cfg.min_throttle});
    hi16 = $signed({4'b0000, cfg.max_throttle});
    for (int i = 0; i < MOTORS; i++) begin
      adj[i] = $signed({m3[i][MIX_W-1], m3[i]}) - $signed({exc3[MIX_W-1], exc3});
      if (adj[i] < lo16) begin
        cmd[i] = cfg.min_throttle;
      end else if (adj[i] > hi16) begin
        cmd[i] = cfg.max_throttle;
      end else begin
        cmd[i] = adj[i][11:0];
      end
      if (idle3) begin
        cmd[i] = IDLE_CMD;
      end
    end
    res.motor_rear_left   = cmd[0];
    res.motor_front_right = cmd[1];
    res.motor_rear_right  = cmd[2];
    res.motor_front_left  = cmd[3];
    res.motor_left        = cmd[4];
    res.motor_right       = cmd[5];
    res.forced_idle       = idle3;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en4) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en4 && s3_valid) begin
      out_item <= res;
    end
  end

endmodule

`default_nettype wire

// File: rtl/hex_x_motor_mixer_unit.sv
// hex_x_motor_mixer_unit: top level, configuration registers and the four-stage mixer pipeline
// depends on hxm_pkg, hxm_mix, hxm_limit
`default_nettype none

// Hexacopter X mixer. One item in, one item out, accepted every cycle when the
// output side keeps up. Four register stages carry each item: pitch product,
// mix sums, peak search, shift and clamp. out_valid rises when the item is held
// in the last of these registers. A stage moves when the one after it is empty
// or moving, so bubbles close up and a stall on out_ready holds every item in
// place. Configuration writes are always taken (cfg_ready is tied high); index 3
// is ignored.

module hex_x_motor_mixer_unit
  import hxm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_item,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_item,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [11:0] cfg_data
);

  cfg_t      cfg;
  logic      mix_valid;
  logic      mix_ready;
  mix_item_t mix_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_throttle <= RST_MIN_THROTTLE;
      cfg.max_throttle <= RST_MAX_THROTTLE;
      cfg.rc_min_check <= RST_RC_MIN_CHECK;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_THROTTLE: cfg.min_throttle <= cfg_data;
        CFG_MAX_THROTTLE: cfg.max_throttle <= cfg_data;
        CFG_RC_MIN_CHECK: cfg.rc_min_check <= cfg_data;
        default: ;
      endcase
    end
  end

  hxm_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (mix_valid),
    .out_ready (mix_ready),
    .out_item  (mix_item)
  );

  hxm_limit u_limit (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (mix_valid),
    .in_ready  (mix_ready),
    .in_item   (mix_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

// File: rtl/hxm_checker.sv
// hxm_checker: port-level checks on the hex-x motor mixer, bound to the top level
// depends on hxm_pkg and hex_x_motor_mixer_unit
`default_nettype none

module hxm_checker
  import hxm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire in_t         in_item,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire out_t        out_item,
  input wire logic        cfg_valid,
  input wire logic        cfg_ready,
  input wire logic [1:0]  cfg_index,
  input wire logic [11:0] cfg_data
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("output item changed while stalled");

  // forced idle means all six commands at the idle value
  a_idle_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.forced_idle |->
      out_item.motor_rear_left == IDLE_CMD && out_item.motor_front_right == IDLE_CMD &&
      out_item.motor_rear_right == IDLE_CMD && out_item.motor_front_left == IDLE_CMD &&
      out_item.motor_left == IDLE_CMD && out_item.motor_right == IDLE_CMD)
    else $error("forced idle with non-idle motor command");

  // pipeline empty after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid right after reset");

  // output side ready lets the input side move
  a_ready_pass: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output side ready");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk) disable iff (rst)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind hex_x_motor_mixer_unit hxm_checker u_hxm_checker (.*);

`default_nettype wire
